// File: rtl/cpurfa_pkg.sv
package cpurfa_pkg;

    // architectural state held in the state memory, one word
    typedef struct packed {
        logic [7:0]  a;
        logic [7:0]  f;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  d;
        logic [7:0]  e;
        logic [7:0]  h;
        logic [7:0]  l;
        logic [15:0] sp;
    } cpurfa_state_t;

    // store request and status that travel with each result item
    typedef struct packed {
        logic        we;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        unknown;
    } cpurfa_store_t;

    localparam int STATE_W = $bits(cpurfa_state_t);

    // power-up register contents
    localparam cpurfa_state_t STATE_RESET = '{
        a:  8'h01,
        f:  8'hB0,
        b:  8'h00,
        c:  8'h13,
        d:  8'h00,
        e:  8'hD8,
        h:  8'h01,
        l:  8'h4D,
        sp: 16'hFFFE
    };

    // 3-bit register operand codes
    localparam logic [2:0] REG_B   = 3'd0;
    localparam logic [2:0] REG_C   = 3'd1;
    localparam logic [2:0] REG_D   = 3'd2;
    localparam logic [2:0] REG_E   = 3'd3;
    localparam logic [2:0] REG_H   = 3'd4;
    localparam logic [2:0] REG_L   = 3'd5;
    localparam logic [2:0] REG_MEM = 3'd6;
    localparam logic [2:0] REG_A   = 3'd7;

    // alu operation codes
    localparam logic [1:0] ALU_ADD = 2'd0;
    localparam logic [1:0] ALU_ADC = 2'd1;
    localparam logic [1:0] ALU_SUB = 2'd2;
    localparam logic [1:0] ALU_SBC = 2'd3;

    // opcodes
    localparam logic [7:0] OP_NOP       = 8'h00;
    localparam logic [7:0] OP_LD_BC_D16 = 8'h01;
    localparam logic [7:0] OP_ST_BC     = 8'h02;
    localparam logic [7:0] OP_INC_BC    = 8'h03;
    localparam logic [7:0] OP_INC_B     = 8'h04;
    localparam logic [7:0] OP_DEC_B     = 8'h05;
    localparam logic [7:0] OP_LD_B_D8   = 8'h06;
    localparam logic [7:0] OP_DEC_C     = 8'h0D;
    localparam logic [7:0] OP_LD_C_D8   = 8'h0E;
    localparam logic [7:0] OP_ST_DE     = 8'h12;
    localparam logic [7:0] OP_DEC_D     = 8'h15;
    localparam logic [7:0] OP_DEC_E     = 8'h1D;
    localparam logic [7:0] OP_ST_HLI    = 8'h22;
    localparam logic [7:0] OP_DEC_H     = 8'h25;
    localparam logic [7:0] OP_DEC_L     = 8'h2D;
    localparam logic [7:0] OP_LD_SP_D16 = 8'h31;
    localparam logic [7:0] OP_ST_HLD    = 8'h32;
    localparam logic [7:0] OP_ADD_D8    = 8'hC6;
    localparam logic [7:0] OP_ADC_D8    = 8'hCE;
    localparam logic [7:0] OP_SUB_D8    = 8'hD6;
    localparam logic [7:0] OP_SBC_D8    = 8'hDE;

    // opcode ranges
    localparam logic [7:0] OP_LD_FIRST   = 8'h40;
    localparam logic [7:0] OP_LD_LAST    = 8'h6F;
    localparam logic [7:0] OP_LDA_FIRST  = 8'h78;
    localparam logic [7:0] OP_LDA_LAST   = 8'h7F;
    localparam logic [7:0] OP_ALU_FIRST  = 8'h80;
    localparam logic [7:0] OP_ALU_LAST   = 8'h9F;

endpackage

// File: rtl/cpurfa_exec.sv
module cpurfa_exec (
    input  cpurfa_pkg::cpurfa_state_t cur,
    input  logic [7:0]                opcode,
    input  logic [7:0]                operand_low,
    input  logic [7:0]                operand_high,
    output cpurfa_pkg::cpurfa_state_t nxt,
    output cpurfa_pkg::cpurfa_store_t store
);
    import cpurfa_pkg::*;

    // register read by operand code, memory operand from the item
    function automatic logic [7:0] get_reg(cpurfa_state_t s, logic [2:0] code,
                                           logic [7:0] mem);
        logic [7:0] v;
        case (code)
            REG_B:   v = s.b;
            REG_C:   v = s.c;
            REG_D:   v = s.d;
            REG_E:   v = s.e;
            REG_H:   v = s.h;
            REG_L:   v = s.l;
            REG_MEM: v = mem;
            default: v = s.a;
        endcase
        return v;
    endfunction

    // register write by operand code, memory code writes nothing
    function automatic cpurfa_state_t put_reg(cpurfa_state_t s, logic [2:0] code,
                                              logic [7:0] v);
        cpurfa_state_t r;
        r = s;
        case (code)
            REG_B:   r.b = v;
            REG_C:   r.c = v;
            REG_D:   r.d = v;
            REG_E:   r.e = v;
            REG_H:   r.h = v;
            REG_L:   r.l = v;
            REG_MEM: r = s;
            default: r.a = v;
        endcase
        return r;
    endfunction

    logic [7:0]  src;
    logic [7:0]  alu_n;
    logic [1:0]  alu_op;
    logic        cin;
    logic        is_sub;
    logic [8:0]  sum9;
    logic [4:0]  hsum5;
    logic [8:0]  dif9;
    logic [4:0]  hdif5;
    logic [7:0]  alu_res;
    logic [7:0]  alu_flags;
    logic [7:0]  id_src;
    logic [7:0]  id_res;
    logic        id_half;
    logic [7:0]  id_flags;
    logic [15:0] bc;
    logic [15:0] de;
    logic [15:0] hl;

    assign bc = {cur.b, cur.c};
    assign de = {cur.d, cur.e};
    assign hl = {cur.h, cur.l};

    // operand selection
    assign src    = get_reg(cur, opcode[2:0], operand_low);
    assign alu_n  = (opcode[7:5] == 3'b100) ? src : operand_low;
    assign alu_op = opcode[4:3];
    assign cin    = ((alu_op == ALU_ADC) || (alu_op == ALU_SBC)) & cur.f[4];
    assign is_sub = (alu_op == ALU_SUB) || (alu_op == ALU_SBC);

    // 8-bit adder and subtractor with nibble carry and borrow
    assign sum9  = {1'b0, cur.a} + {1'b0, alu_n} + {8'b0, cin};
    assign hsum5 = {1'b0, cur.a[3:0]} + {1'b0, alu_n[3:0]} + {4'b0, cin};
    assign dif9  = {1'b0, cur.a} - {1'b0, alu_n} - {8'b0, cin};
    assign hdif5 = {1'b0, cur.a[3:0]} - {1'b0, alu_n[3:0]} - {4'b0, cin};

    assign alu_res   = is_sub ? dif9[7:0] : sum9[7:0];
    assign alu_flags = {alu_res == 8'h00, is_sub,
                        is_sub ? hdif5[4] : hsum5[4],
                        is_sub ? dif9[8] : sum9[8], 4'h0};

    // 8-bit increment and decrement, carry kept
    assign id_src   = get_reg(cur, opcode[5:3], operand_low);
    assign id_res   = opcode[0] ? id_src - 8'd1 : id_src + 8'd1;
    assign id_half  = opcode[0] ? (id_res[3:0] == 4'hF) : (id_res[3:0] == 4'h0);
    assign id_flags = {id_res == 8'h00, opcode[0], id_half, cur.f[4], 4'h0};

    // decode and next state
    always_comb
    begin
        nxt   = cur;
        store = '0;
        if (opcode inside {[OP_LD_FIRST:OP_LD_LAST], [OP_LDA_FIRST:OP_LDA_LAST]})
        begin
            nxt = put_reg(cur, opcode[5:3], src);
        end
        else if (opcode inside {[OP_ALU_FIRST:OP_ALU_LAST]})
        begin
            nxt.a = alu_res;
            nxt.f = alu_flags;
        end
        else
        begin
            case (opcode)
                OP_NOP:
                begin
                    nxt = cur;
                end
                OP_LD_BC_D16:
                begin
                    nxt.b = operand_high;
                    nxt.c = operand_low;
                end
                OP_ST_BC:
                begin
                    store.we   = 1'b1;
                    store.addr = bc;
                    store.data = cur.a;
                end
                OP_INC_BC:
                begin
                    {nxt.b, nxt.c} = bc + 16'd1;
                end
                OP_INC_B, OP_DEC_B, OP_DEC_C, OP_DEC_D, OP_DEC_E, OP_DEC_H, OP_DEC_L:
                begin
                    nxt   = put_reg(cur, opcode[5:3], id_res);
                    nxt.f = id_flags;
                end
                OP_LD_B_D8:
                begin
                    nxt.b = operand_low;
                end
                OP_LD_C_D8:
                begin
                    nxt.c = operand_low;
                end
                OP_ST_DE:
                begin
                    store.we   = 1'b1;
                    store.addr = de;
                    store.data = cur.a;
                end
                OP_ST_HLI:
                begin
                    store.we       = 1'b1;
                    store.addr     = hl;
                    store.data     = cur.a;
                    {nxt.h, nxt.l} = hl + 16'd1;
                end
                OP_ST_HLD:
                begin
                    store.we       = 1'b1;
                    store.addr     = hl;
                    store.data     = cur.a;
                    {nxt.h, nxt.l} = hl - 16'd1;
                end
                OP_LD_SP_D16:
                begin
                    nxt.sp = {operand_high, operand_low};
                end
                OP_ADD_D8, OP_ADC_D8, OP_SUB_D8, OP_SBC_D8:
                begin
                    nxt.a = alu_res;
                    nxt.f = alu_flags;
                end
                default:
                begin
                    store.unknown = 1'b1;
                end
            endcase
        end
        // low flag nibble always reads zero
        nxt.f[3:0] = 4'h0;
    end

endmodule

// File: rtl/cpu_register_file_alu_execute.sv
// Pipeline: an accepted item is registered into the execute stage, executes
// there, and its result item is registered out once the output is not stalled.
// Throughput: one item per cycle unless the output stalls; state memory is
// read each cycle; the word from the item ahead bypasses the registered read.
// Reset: control clears at once; until the first write the state word reads
// as the power-up register values (A=01 F=B0 BC=0013 DE=00D8 HL=014D SP=FFFE).
module cpu_register_file_alu_execute (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  opcode,
    input  logic [7:0]  operand_low,
    input  logic [7:0]  operand_high,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  accumulator,
    output logic [7:0]  flag_bits,
    output logic [15:0] pair_bc,
    output logic [15:0] pair_de,
    output logic [15:0] pair_hl,
    output logic [15:0] stack_value,
    output logic        write_enable,
    output logic [15:0] write_address,
    output logic [7:0]  write_data,
    output logic        illegal_opcode
);
    import cpurfa_pkg::*;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [7:0]          s1_opcode_reg;
    logic [7:0]          s1_low_reg;
    logic [7:0]          s1_high_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    cpurfa_state_t       out_state_reg;
    cpurfa_store_t       out_store_reg;
    logic                init_reg;
    logic                init_next;
    logic                fwd_valid_reg;
    logic                fwd_valid_next;
    cpurfa_state_t       fwd_data_reg;
    logic [STATE_W-1:0]  rd_data_reg;
    logic [STATE_W-1:0]  state_mem [0:0];
    cpurfa_state_t       cur_state;
    cpurfa_state_t       exec_state;
    cpurfa_store_t       exec_store;
    logic                accept;
    logic                advance;

    // handshake
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    // current state: forwarded write, memory word, or power-up values
    always_comb
    begin
        if (fwd_valid_reg)
        begin
            cur_state = fwd_data_reg;
        end
        else if (init_reg)
        begin
            cur_state = cpurfa_state_t'(rd_data_reg);
        end
        else
        begin
            cur_state = STATE_RESET;
        end
    end

    // execute unit
    cpurfa_exec u_exec (
        .cur          (cur_state),
        .opcode       (s1_opcode_reg),
        .operand_low  (s1_low_reg),
        .operand_high (s1_high_reg),
        .nxt          (exec_state),
        .store        (exec_store)
    );

    // control next values
    always_comb
    begin
        s1_valid_next  = accept || (s1_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && out_stall);
        init_next      = init_reg || advance;
        fwd_valid_next = advance;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            init_reg      <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            init_reg      <= init_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_opcode_reg <= opcode;
            s1_low_reg    <= operand_low;
            s1_high_reg   <= operand_high;
        end
        if (advance)
        begin
            out_state_reg <= exec_state;
            out_store_reg <= exec_store;
            fwd_data_reg  <= exec_state;
        end
    end

    // state memory, registered read
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_mem[0] <= STATE_W'(exec_state);
        end
        rd_data_reg <= state_mem[0];
    end

    // result ports
    assign out_valid      = out_valid_reg;
    assign accumulator    = out_state_reg.a;
    assign flag_bits      = out_state_reg.f;
    assign pair_bc        = {out_state_reg.b, out_state_reg.c};
    assign pair_de        = {out_state_reg.d, out_state_reg.e};
    assign pair_hl        = {out_state_reg.h, out_state_reg.l};
    assign stack_value    = out_state_reg.sp;
    assign write_enable   = out_store_reg.we;
    assign write_address  = out_store_reg.addr;
    assign write_data     = out_store_reg.data;
    assign illegal_opcode = out_store_reg.unknown;

`ifndef SYNTH
    // input is held back only while a result waits on a stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a blocked result");

    // low nibble of the flags never set
    a_flag_nibble: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (flag_bits[3:0] == 4'h0))
        else $error("flag low nibble not zero");

    // an unimplemented opcode never stores
    a_unknown_no_store: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && illegal_opcode) |-> !write_enable)
        else $error("unknown opcode produced a store");

    // a result moves out only after an execute slot was occupied
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s1_valid_reg))
        else $error("result appeared without an item in execute");
`endif

endmodule

// File: sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cpurfa_pkg::*;

    // flag register bit positions
    localparam int FLAG_Z_BIT = 7;
    localparam int FLAG_N_BIT = 6;
    localparam int FLAG_H_BIT = 5;
    localparam int FLAG_C_BIT = 4;

    localparam int RANDOM_ITEMS     = 1500;
    localparam int LONG_HOLD_AT     = 300;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int WATCHDOG_LIMIT   = 1000;

    // register file after one instruction plus its store request
    typedef struct packed {
        cpurfa_state_t regs;
        cpurfa_store_t store;
    } executed_t;

    // tracks the architectural state and the results still owed by the block
    class execute_checker;
        cpurfa_state_t regs;
        executed_t     predicted[$];
        int            mismatches;
        int            results_seen;

        function new();
            regs         = STATE_RESET;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function logic [7:0] read_reg(logic [2:0] code, logic [7:0] mem);
            case (code)
                REG_B:   return regs.b;
                REG_C:   return regs.c;
                REG_D:   return regs.d;
                REG_E:   return regs.e;
                REG_H:   return regs.h;
                REG_L:   return regs.l;
                REG_MEM: return mem;
                default: return regs.a;
            endcase
        endfunction

        function void write_reg(logic [2:0] code, logic [7:0] v);
            case (code)
                REG_B:   regs.b = v;
                REG_C:   regs.c = v;
                REG_D:   regs.d = v;
                REG_E:   regs.e = v;
                REG_H:   regs.h = v;
                REG_L:   regs.l = v;
                REG_MEM: ;
                default: regs.a = v;
            endcase
        endfunction

        // 8-bit add or subtract into A, carry in only for the with-carry forms
        function void alu_op(logic [1:0] kind, logic [7:0] n);
            logic       cin;
            logic [8:0] full;
            logic [4:0] half;
            logic [7:0] f;
            cin = (kind == ALU_ADC || kind == ALU_SBC) ? regs.f[FLAG_C_BIT] : 1'b0;
            f   = '0;
            if (kind == ALU_ADD || kind == ALU_ADC)
            begin
                full = {1'b0, regs.a} + {1'b0, n} + {8'd0, cin};
                half = {1'b0, regs.a[3:0]} + {1'b0, n[3:0]} + {4'd0, cin};
            end
            else
            begin
                full = {1'b0, regs.a} - {1'b0, n} - {8'd0, cin};
                half = {1'b0, regs.a[3:0]} - {1'b0, n[3:0]} - {4'd0, cin};
                f[FLAG_N_BIT] = 1'b1;
            end
            f[FLAG_H_BIT] = half[4];
            f[FLAG_C_BIT] = full[8];
            f[FLAG_Z_BIT] = (full[7:0] == 8'd0);
            regs.a = full[7:0];
            regs.f = f;
        endfunction

        // single register increment or decrement, carry kept
        function void inc_dec(logic [2:0] code, logic dec);
            logic [7:0] v;
            logic [7:0] f;
            v = dec ? read_reg(code, 8'd0) - 8'd1 : read_reg(code, 8'd0) + 8'd1;
            f = '0;
            f[FLAG_C_BIT] = regs.f[FLAG_C_BIT];
            f[FLAG_N_BIT] = dec;
            f[FLAG_H_BIT] = dec ? (v[3:0] == 4'hF) : (v[3:0] == 4'h0);
            f[FLAG_Z_BIT] = (v == 8'd0);
            write_reg(code, v);
            regs.f = f;
        endfunction

        // execute one accepted instruction and queue the register file it leaves
        function void note_instruction(logic [7:0] op, logic [7:0] lo, logic [7:0] hi);
            cpurfa_store_t st;
            executed_t     res;
            st = '0;
            if (op inside {[OP_LD_FIRST:OP_LD_LAST], [OP_LDA_FIRST:OP_LDA_LAST]})
            begin
                write_reg(op[5:3], read_reg(op[2:0], lo));
            end
            else if (op inside {[OP_ALU_FIRST:OP_ALU_LAST]})
            begin
                alu_op(op[4:3], read_reg(op[2:0], lo));
            end
            else
            begin
                case (op)
                    OP_NOP: ;
                    OP_LD_BC_D16: {regs.b, regs.c} = {hi, lo};
                    OP_ST_BC:
                    begin
                        st.we   = 1'b1;
                        st.addr = {regs.b, regs.c};
                        st.data = regs.a;
                    end
                    OP_INC_BC:  {regs.b, regs.c} = {regs.b, regs.c} + 16'd1;
                    OP_INC_B:   inc_dec(REG_B, 1'b0);
                    OP_DEC_B:   inc_dec(REG_B, 1'b1);
                    OP_LD_B_D8: regs.b = lo;
                    OP_DEC_C:   inc_dec(REG_C, 1'b1);
                    OP_LD_C_D8: regs.c = lo;
                    OP_ST_DE:
                    begin
                        st.we   = 1'b1;
                        st.addr = {regs.d, regs.e};
                        st.data = regs.a;
                    end
                    OP_DEC_D: inc_dec(REG_D, 1'b1);
                    OP_DEC_E: inc_dec(REG_E, 1'b1);
                    OP_ST_HLI, OP_ST_HLD:
                    begin
                        st.we   = 1'b1;
                        st.addr = {regs.h, regs.l};
                        st.data = regs.a;
                        if (op == OP_ST_HLI)
                            {regs.h, regs.l} = {regs.h, regs.l} + 16'd1;
                        else
                            {regs.h, regs.l} = {regs.h, regs.l} - 16'd1;
                    end
                    OP_DEC_H:     inc_dec(REG_H, 1'b1);
                    OP_DEC_L:     inc_dec(REG_L, 1'b1);
                    OP_LD_SP_D16: regs.sp = {hi, lo};
                    OP_ADD_D8:    alu_op(ALU_ADD, lo);
                    OP_ADC_D8:    alu_op(ALU_ADC, lo);
                    OP_SUB_D8:    alu_op(ALU_SUB, lo);
                    OP_SBC_D8:    alu_op(ALU_SBC, lo);
                    default:      st.unknown = 1'b1;
                endcase
            end
            regs.f[3:0] = 4'h0;
            res.regs  = regs;
            res.store = st;
            predicted.push_back(res);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
        endtask

        // compare one accepted result with the oldest prediction
        task check_result(executed_t got);
            executed_t want;
            results_seen++;
            if (predicted.size() == 0)
            begin
                report_mismatch("result item with no instruction outstanding");
                return;
            end
            want = predicted.pop_front();
            compare_field("accumulator", 16'(got.regs.a), 16'(want.regs.a));
            compare_field("flag_bits", 16'(got.regs.f), 16'(want.regs.f));
            compare_field("pair_bc", {got.regs.b, got.regs.c}, {want.regs.b, want.regs.c});
            compare_field("pair_de", {got.regs.d, got.regs.e}, {want.regs.d, want.regs.e});
            compare_field("pair_hl", {got.regs.h, got.regs.l}, {want.regs.h, want.regs.l});
            compare_field("stack_value", got.regs.sp, want.regs.sp);
            compare_field("write_enable", 16'(got.store.we), 16'(want.store.we));
            compare_field("write_address", got.store.addr, want.store.addr);
            compare_field("write_data", 16'(got.store.data), 16'(want.store.data));
            compare_field("illegal_opcode", 16'(got.store.unknown),
                          16'(want.store.unknown));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  opcode;
    logic [7:0]  operand_low;
    logic [7:0]  operand_high;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  accumulator;
    logic [7:0]  flag_bits;
    logic [15:0] pair_bc;
    logic [15:0] pair_de;
    logic [15:0] pair_hl;
    logic [15:0] stack_value;
    logic        write_enable;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic        illegal_opcode;

    executed_t      seen;
    execute_checker chk;
    logic           steady;
    int             idle_cycles;
    logic [7:0]     known_ops[$];

    cpu_register_file_alu_execute uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .operand_low    (operand_low),
        .operand_high   (operand_high),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .accumulator    (accumulator),
        .flag_bits      (flag_bits),
        .pair_bc        (pair_bc),
        .pair_de        (pair_de),
        .pair_hl        (pair_hl),
        .stack_value    (stack_value),
        .write_enable   (write_enable),
        .write_address  (write_address),
        .write_data     (write_data),
        .illegal_opcode (illegal_opcode)
    );

    // output ports packed in the same order as the expected result
    assign seen = {accumulator, flag_bits, pair_bc, pair_de, pair_hl, stack_value,
                   write_enable, write_address, write_data, illegal_opcode};

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // offer one instruction after a random gap (none while steady) and hold it until taken
    task automatic send_instruction(input logic [7:0] op, input logic [7:0] lo,
                                    input logic [7:0] hi);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 7);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        opcode       <= op;
        operand_low  <= lo;
        operand_high <= hi;
        do @(posedge clk); while (in_stall);
    endtask

    // operand byte biased towards the carry and zero boundaries
    function automatic logic [7:0] operand_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h0F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // receiver: random stall before each result, one long hold-off to back up the block
    initial
    begin
        int unsigned hold;
        int          taken;
        out_stall = 1'b0;
        taken     = 0;
        @(posedge rst_n);
        forever
        begin
            if (taken == LONG_HOLD_AT)
                hold = LONG_HOLD_CYCLES;
            else
                hold = steady ? 0 : $urandom_range(0, 7);
            repeat (hold)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                @(posedge clk);
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    // handshake monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                chk.check_result(seen);
            if (in_valid && !in_stall)
                chk.note_instruction(opcode, operand_low, operand_high);
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [7:0] op;
        in_valid     = 1'b0;
        opcode       = 8'h00;
        operand_low  = 8'h00;
        operand_high = 8'h00;
        rst_n        = 1'b0;
        steady       = 1'b0;
        idle_cycles  = 0;
        chk          = new();

        // opcodes the block implements, for the weighted random part
        known_ops = '{OP_NOP, OP_LD_BC_D16, OP_ST_BC, OP_INC_BC, OP_INC_B, OP_DEC_B,
                      OP_LD_B_D8, OP_DEC_C, OP_LD_C_D8, OP_ST_DE, OP_DEC_D, OP_DEC_E,
                      OP_ST_HLI, OP_DEC_H, OP_DEC_L, OP_LD_SP_D16, OP_ST_HLD,
                      OP_ADD_D8, OP_ADC_D8, OP_SUB_D8, OP_SBC_D8};
        for (int v = OP_LD_FIRST; v <= OP_LD_LAST; v++)
            known_ops.push_back(8'(v));
        for (int v = OP_LDA_FIRST; v <= OP_ALU_LAST; v++)
            known_ops.push_back(8'(v));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: 16-bit wrap, inc/dec boundaries, stores, flag extremes, unknowns
        send_instruction(OP_NOP, 8'hFF, 8'hFF);
        send_instruction(OP_LD_BC_D16, 8'hFF, 8'hFF);
        send_instruction(OP_INC_BC, 8'h00, 8'h00);
        send_instruction(OP_LD_SP_D16, 8'h00, 8'h00);
        send_instruction(OP_LD_B_D8, 8'hFF, 8'h00);
        send_instruction(OP_INC_B, 8'h00, 8'h00);
        send_instruction(OP_DEC_B, 8'h00, 8'h00);
        send_instruction(OP_LD_C_D8, 8'h01, 8'h00);
        send_instruction(OP_DEC_C, 8'h00, 8'h00);
        send_instruction(8'h66, 8'hFF, 8'h00);
        send_instruction(8'h6E, 8'hFF, 8'h00);
        send_instruction(OP_ST_HLI, 8'h00, 8'h00);
        send_instruction(OP_ST_HLD, 8'h00, 8'h00);
        send_instruction(OP_ST_BC, 8'h00, 8'h00);
        send_instruction(OP_ST_DE, 8'h00, 8'h00);
        send_instruction(OP_DEC_D, 8'h00, 8'h00);
        send_instruction(OP_DEC_E, 8'h00, 8'h00);
        send_instruction(OP_ADD_D8, 8'hFF, 8'h00);
        send_instruction(OP_ADC_D8, 8'hFF, 8'h00);
        send_instruction(OP_SUB_D8, 8'h01, 8'h00);
        send_instruction(OP_SBC_D8, 8'hFF, 8'h00);
        send_instruction(8'h7E, 8'h80, 8'h00);
        send_instruction(8'h86, 8'h80, 8'h00);
        send_instruction(8'h76, 8'hAA, 8'h55);
        send_instruction(8'hFF, 8'h55, 8'hAA);

        // random: mostly implemented opcodes, some fully random bytes
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            steady = ((k / 100) % 4 == 2);
            if ($urandom_range(0, 9) == 0)
                op = 8'($urandom_range(0, 255));
            else
                op = known_ops[$urandom_range(0, known_ops.size() - 1)];
            send_instruction(op, operand_byte(), operand_byte());
        end
        steady = 1'b0;
        @(negedge clk);
        in_valid <= 1'b0;

        // drain, then allow for anything the block might still emit
        while (chk.predicted.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (chk.mismatches == 0 && chk.predicted.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
